[hw/rtl/ecnmf_pkg.sv]
`default_nettype none
package ecnmf_pkg;

	// Event codes
	localparam logic [2:0] FUNC_ACK      = 3'd0;
	localparam logic [2:0] FUNC_INIT     = 3'd1;
	localparam logic [2:0] FUNC_SSTHRESH = 3'd2;
	localparam logic [2:0] FUNC_LOSS     = 3'd3;
	localparam logic [2:0] FUNC_UNDO     = 3'd4;

	// Register indexes (byte address bit 2)
	localparam logic REG_GAIN_SHIFT    = 1'b0;
	localparam logic REG_INITIAL_ALPHA = 1'b1;
	localparam int   ADDR_W            = 3;

	localparam logic [10:0] ALPHA_MAX      = 11'd1024;
	localparam logic [3:0]  ALPHA_BITS     = 4'd10;
	localparam int          SSTHRESH_SHIFT = 11;
	localparam logic [21:0] WINDOW_FLOOR   = 22'd2;
	localparam logic [3:0]  GAIN_RESET     = 4'd4;
	localparam logic [10:0] INIT_RESET     = 11'd1024;
	localparam int          DIV_STEPS      = 32;

	typedef struct packed {
		logic idle;
		logic load;
		logic eval;
		logic div_step;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_div;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

[hw/rtl/ecnmf_if.sv]
`default_nettype none
interface ecnmf_evt_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [31:0] acked_seq;
	logic [31:0] send_next_seq;
	logic [31:0] delivered_count;
	logic [31:0] marked_count;
	logic [21:0] cwnd;

	modport source (output valid, func, acked_seq, send_next_seq, delivered_count,
		marked_count, cwnd, input ready);
	modport sink (input valid, func, acked_seq, send_next_seq, delivered_count,
		marked_count, cwnd, output ready);
endinterface

interface ecnmf_res_if;
	logic        valid;
	logic        ready;
	logic [10:0] alpha_now;
	logic [21:0] window_value;
	logic        window_expired;

	modport source (output valid, alpha_now, window_value, window_expired, input ready);
	modport sink (input valid, alpha_now, window_value, window_expired, output ready);
endinterface
`default_nettype wire

[hw/rtl/ecnmf_ctrl.sv]
`default_nettype none
module ecnmf_ctrl (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	input  ecnmf_pkg::dp_status_t    status,
	output ecnmf_pkg::ctrl_cmd_t     cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EVAL = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	localparam logic [4:0] LAST_STEP = 5'(ecnmf_pkg::DIV_STEPS - 1);

	logic [1:0] state_q, state_d;
	logic [4:0] cnt_q, cnt_d;

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		cmd          = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.idle = 1'b1;
				cmd.load = in_valid;
				if (in_valid) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				cnt_d    = '0;
				state_d  = status.need_div ? S_DIV : S_DONE;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 5'd1;
				if (cnt_q == LAST_STEP) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// The result waits here until the output register can take it.
				cmd.commit = status.out_free;
				if (status.out_free) begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/ecnmf_dp.sv]
`default_nettype none
module ecnmf_dp (
	input  wire                      clk,
	input  wire                      arst_n,
	input  ecnmf_pkg::ctrl_cmd_t     cmd,
	output ecnmf_pkg::dp_status_t    status,
	input  wire  [3:0]               gain_shift,
	input  wire  [10:0]              initial_alpha,
	ecnmf_evt_if.sink                evt,
	ecnmf_res_if.source              res
);

	// Captured item
	logic [2:0]  func_q;
	logic [31:0] acked_q, snd_next_q, deliv_q, marked_q;
	logic [21:0] cwnd_q;

	// Flow state
	logic [10:0] alpha_q;
	logic [31:0] wend_q, dsnap_q, msnap_q;
	logic [21:0] wbl_q;

	// Evaluation and divider registers
	logic        exp_q;
	logic [10:0] acc_q;
	logic [32:0] prod_q;
	logic [31:0] rem_q, quo_q, dvs_q;

	// Output register
	logic        out_valid_q;
	logic [10:0] out_alpha_q;
	logic [21:0] out_win_q;
	logic        out_exp_q;

	logic [3:0]  g, sh;
	logic [31:0] seq_gap, mdelta, ddelta, divisor_in, scaled;
	logic [10:0] decayed;
	logic        expired_c;
	logic [32:0] shifted, diff;
	logic        ge;
	logic [32:0] sum;
	logic [10:0] sat_alpha, init_cap;
	logic [21:0] cut, ss_raw, ss_win, half, loss_win, undo_win;
	logic [10:0] alpha_next;
	logic [21:0] win_next;
	logic        exp_next, wbl_load, snap_load;
	logic [21:0] wbl_next;

	assign g          = (gain_shift > ecnmf_pkg::ALPHA_BITS) ? ecnmf_pkg::ALPHA_BITS : gain_shift;
	assign sh         = ecnmf_pkg::ALPHA_BITS - g;
	assign seq_gap    = acked_q - wend_q;
	assign mdelta     = marked_q - msnap_q;
	assign ddelta     = deliv_q - dsnap_q;
	assign divisor_in = (ddelta == 32'd0) ? 32'd1 : ddelta;
	assign scaled     = mdelta << sh;
	assign decayed    = alpha_q - (alpha_q >> g);
	assign expired_c  = (func_q == ecnmf_pkg::FUNC_ACK) && !seq_gap[31];

	assign status.need_div = expired_c && (mdelta != 32'd0);
	assign status.out_free = !out_valid_q || res.ready;

	// Restoring divider: one quotient bit per step, dividend shifts out of quo_q.
	assign shifted = {rem_q, quo_q[31]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign ge      = !diff[32];

	// Quotient is zero when no division ran, so the sum is just the decayed alpha.
	assign sum       = {22'd0, acc_q} + {1'b0, quo_q};
	assign sat_alpha = (sum > 33'(ecnmf_pkg::ALPHA_MAX)) ? ecnmf_pkg::ALPHA_MAX : sum[10:0];
	assign init_cap  = (initial_alpha > ecnmf_pkg::ALPHA_MAX) ? ecnmf_pkg::ALPHA_MAX
		: initial_alpha;

	assign cut      = prod_q[32:ecnmf_pkg::SSTHRESH_SHIFT];
	assign ss_raw   = cwnd_q - cut;
	assign ss_win   = (ss_raw < ecnmf_pkg::WINDOW_FLOOR) ? ecnmf_pkg::WINDOW_FLOOR : ss_raw;
	assign half     = {1'b0, cwnd_q[21:1]};
	assign loss_win = (half < ecnmf_pkg::WINDOW_FLOOR) ? ecnmf_pkg::WINDOW_FLOOR : half;
	assign undo_win = (cwnd_q > wbl_q) ? cwnd_q : wbl_q;

	always_comb begin
		alpha_next = alpha_q;
		win_next   = '0;
		exp_next   = 1'b0;
		wbl_load   = 1'b0;
		wbl_next   = cwnd_q;
		snap_load  = 1'b0;
		unique case (func_q)
			ecnmf_pkg::FUNC_ACK: begin
				if (exp_q) begin
					alpha_next = sat_alpha;
					exp_next   = 1'b1;
					snap_load  = 1'b1;
				end
			end
			ecnmf_pkg::FUNC_INIT: begin
				alpha_next = init_cap;
				wbl_load   = 1'b1;
				wbl_next   = '0;
				snap_load  = 1'b1;
			end
			ecnmf_pkg::FUNC_SSTHRESH: begin
				wbl_load = 1'b1;
				win_next = ss_win;
			end
			ecnmf_pkg::FUNC_LOSS: begin
				wbl_load = 1'b1;
				win_next = loss_win;
			end
			ecnmf_pkg::FUNC_UNDO: begin
				win_next = undo_win;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q     <= evt.func;
			acked_q    <= evt.acked_seq;
			snd_next_q <= evt.send_next_seq;
			deliv_q    <= evt.delivered_count;
			marked_q   <= evt.marked_count;
			cwnd_q     <= evt.cwnd;
		end
		if (cmd.eval) begin
			exp_q  <= expired_c;
			acc_q  <= decayed;
			prod_q <= 33'(cwnd_q) * 33'(alpha_q);
			rem_q  <= '0;
			quo_q  <= status.need_div ? scaled : 32'd0;
			dvs_q  <= divisor_in;
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[31:0] : shifted[31:0];
			quo_q <= {quo_q[30:0], ge};
		end
		if (cmd.commit) begin
			out_alpha_q <= alpha_next;
			out_win_q   <= win_next;
			out_exp_q   <= exp_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q     <= ecnmf_pkg::ALPHA_MAX;
			wend_q      <= '0;
			dsnap_q     <= '0;
			msnap_q     <= '0;
			wbl_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				alpha_q <= alpha_next;
				if (wbl_load) begin
					wbl_q <= wbl_next;
				end
				if (snap_load) begin
					wend_q  <= snd_next_q;
					dsnap_q <= deliv_q;
					msnap_q <= marked_q;
				end
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid          = out_valid_q;
	assign res.alpha_now      = out_alpha_q;
	assign res.window_value   = out_win_q;
	assign res.window_expired = out_exp_q;

endmodule
`default_nettype wire

[hw/rtl/ecn_mark_fraction_estimator.sv]
// DCTCP-style marking fraction estimator for one flow. Each accepted item gives exactly one
// result item. For most events the item is evaluated and the result then written to the output
// register once that register is free. An ack that closes its window with a nonzero marked
// delta also runs the restoring divider between the two, which produces one quotient bit per
// cycle. One item is processed at a time; the next item is accepted once the previous result
// has entered the output register, even if that result has not yet been taken. Registers sit on
// an APB port: gain_shift at byte address 0, initial_alpha at byte address 4.
`default_nettype none
module ecn_mark_fraction_estimator (
	input  wire                                  clk,
	input  wire                                  arst_n,
	ecnmf_evt_if.sink                            evt,
	ecnmf_res_if.source                          res,
	input  wire                                  psel,
	input  wire                                  penable,
	input  wire                                  pwrite,
	input  wire  [ecnmf_pkg::ADDR_W-1:0]         paddr,
	input  wire  [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);

	logic [3:0]  gain_q;
	logic [10:0] init_q;
	logic        cfg_wr;

	ecnmf_pkg::ctrl_cmd_t  cmd;
	ecnmf_pkg::dp_status_t status;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= ecnmf_pkg::GAIN_RESET;
			init_q <= ecnmf_pkg::INIT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				ecnmf_pkg::REG_GAIN_SHIFT:    gain_q <= pwdata[3:0];
				ecnmf_pkg::REG_INITIAL_ALPHA: init_q <= pwdata[10:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			ecnmf_pkg::REG_GAIN_SHIFT:    prdata = {28'd0, gain_q};
			ecnmf_pkg::REG_INITIAL_ALPHA: prdata = {21'd0, init_q};
		endcase
	end

	assign evt.ready = cmd.idle;

	ecnmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (evt.valid),
		.status   (status),
		.cmd      (cmd)
	);

	ecnmf_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.gain_shift    (gain_q),
		.initial_alpha (init_q),
		.evt           (evt),
		.res           (res)
	);

	// Only one item may be in flight: the cycle after an accept never accepts.
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid && evt.ready |=> !evt.ready)
		else $error("item accepted while another is in flight");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> res.valid)
		else $error("committed result not presented");

	a_alpha_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.alpha_now <= ecnmf_pkg::ALPHA_MAX)
		else $error("alpha above full scale");

	a_expired_no_window: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.window_expired |-> res.window_value == 22'd0)
		else $error("closed window reported with a window value");

endmodule
`default_nettype wire

[verif/ecnmf_alpha_checker.sv]
`timescale 1ns / 1ps
module ecnmf_alpha_checker (
	input  wire                          clk,
	input  wire                          arst_n,
	ecnmf_evt_if                         evt,
	ecnmf_res_if                         res,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [ecnmf_pkg::ADDR_W-1:0] paddr,
	input  wire  [31:0]                  pwdata,
	input  wire                          pready,
	output int unsigned                  errors,
	output int unsigned                  outstanding
);
	import ecnmf_pkg::*;

	typedef struct packed {
		logic [10:0] alpha;
		logic [21:0] window;
		logic        expired;
	} estimate_t;

	logic [3:0]  gain_cfg;
	logic [10:0] init_alpha_cfg;
	logic [10:0] alpha_est;
	logic [31:0] window_end;
	logic [31:0] delivered_snap;
	logic [31:0] marked_snap;
	logic [21:0] window_before_loss;
	estimate_t   estimates_due[$];
	int unsigned fails;

	function automatic logic [21:0] floor_two(input logic [21:0] w);
		return (w < WINDOW_FLOOR) ? WINDOW_FLOOR : w;
	endfunction

	// Applies one event to the local copy of the estimator state and returns its result.
	function automatic estimate_t estimate_event(input logic [2:0] func,
		input logic [31:0] acked, input logic [31:0] snd_next, input logic [31:0] deliv,
		input logic [31:0] marked, input logic [21:0] cwnd);
		estimate_t   r;
		logic [3:0]  g;
		logic [31:0] seq_gap;
		logic [31:0] mdelta;
		logic [31:0] ddelta;
		logic [63:0] widened;
		logic [32:0] sum;
		logic [32:0] product;
		logic [32:0] cut;
		r = '0;
		g = (gain_cfg > ALPHA_BITS) ? ALPHA_BITS : gain_cfg;
		case (func)
		FUNC_ACK: begin
			seq_gap = acked - window_end;
			if (!seq_gap[31]) begin
				sum = {22'd0, alpha_est} - {22'd0, alpha_est >> g};
				mdelta = marked - marked_snap;
				if (mdelta != 0) begin
					ddelta = deliv - delivered_snap;
					if (ddelta == 0)
						ddelta = 32'd1;
					// The scaled marked delta is cut to 32 bits before the divide.
					widened = {32'd0, mdelta} << (ALPHA_BITS - g);
					sum = sum + {1'b0, widened[31:0] / ddelta};
					if (sum > {22'd0, ALPHA_MAX})
						sum = {22'd0, ALPHA_MAX};
				end
				alpha_est = sum[10:0];
				window_end = snd_next;
				delivered_snap = deliv;
				marked_snap = marked;
				r.expired = 1'b1;
			end
		end
		FUNC_INIT: begin
			alpha_est = (init_alpha_cfg > ALPHA_MAX) ? ALPHA_MAX : init_alpha_cfg;
			window_before_loss = '0;
			window_end = snd_next;
			delivered_snap = deliv;
			marked_snap = marked;
		end
		FUNC_SSTHRESH: begin
			product = {11'd0, cwnd} * {22'd0, alpha_est};
			cut = product >> SSTHRESH_SHIFT;
			window_before_loss = cwnd;
			r.window = floor_two(cwnd - cut[21:0]);
		end
		FUNC_LOSS: begin
			window_before_loss = cwnd;
			r.window = floor_two(cwnd >> 1);
		end
		FUNC_UNDO: begin
			r.window = (cwnd > window_before_loss) ? cwnd : window_before_loss;
		end
		default: begin
		end
		endcase
		r.alpha = alpha_est;
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want_v,
		input int unsigned got_v);
		if (want_v != got_v) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		estimate_t got;
		estimate_t want;
		if (!arst_n) begin
			gain_cfg = GAIN_RESET;
			init_alpha_cfg = INIT_RESET;
			alpha_est = ALPHA_MAX;
			window_end = '0;
			delivered_snap = '0;
			marked_snap = '0;
			window_before_loss = '0;
			estimates_due.delete();
			fails = 0;
			errors <= 0;
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_GAIN_SHIFT)
					gain_cfg = pwdata[3:0];
				else
					init_alpha_cfg = pwdata[10:0];
			end
			// Results are retired before new items are queued so that a stray result
			// can never be matched against an item accepted in the same cycle.
			if (res.valid && res.ready) begin
				got = {res.alpha_now, res.window_value, res.window_expired};
				if (estimates_due.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual alpha %0d window %0d expired %0b",
						$time, got.alpha, got.window, got.expired);
					fails++;
				end else begin
					want = estimates_due.pop_front();
					check_field("alpha_now", want.alpha, got.alpha);
					check_field("window_value", want.window, got.window);
					check_field("window_expired", want.expired, got.expired);
				end
			end
			if (evt.valid && evt.ready)
				estimates_due.push_back(estimate_event(evt.func, evt.acked_seq, evt.send_next_seq,
					evt.delivered_count, evt.marked_count, evt.cwnd));
			errors <= fails;
			outstanding <= estimates_due.size();
		end
	end

endmodule

[verif/tb_ecn_mark_fraction_estimator.sv]
`timescale 1ns / 1ps
module tb_ecn_mark_fraction_estimator;
	import ecnmf_pkg::*;

	localparam logic [3:0]  GAIN_PLAN [8] = '{4'd0, 4'd15, 4'd10, 4'd1, 4'd4, 4'd7, 4'd0, 4'd9};
	localparam logic [10:0] INIT_PLAN [8] = '{11'd2047, 11'd0, 11'd1024, 11'd1, 11'd300,
		11'd1023, 11'd0, 11'd1025};
	localparam int RANDOM_PHASE = 6;
	localparam int HOLD_PHASE = 1;
	localparam int STEADY_PHASE = 2;
	localparam int ITEMS_PER_PHASE = 122;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	int unsigned       mismatches;
	int unsigned       in_flight;
	bit                source_gaps;
	bit                sink_gaps;
	bit                hold_request;

	// Sequence and counter state of the simulated flow.
	logic [31:0] una;
	logic [31:0] nxt;
	logic [31:0] dlv;
	logic [31:0] mrk;

	ecnmf_evt_if evt_ch();
	ecnmf_res_if res_ch();

	ecn_mark_fraction_estimator i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.evt     (evt_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	ecnmf_alpha_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.evt         (evt_ch),
		.res         (res_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.errors      (mismatches),
		.outstanding (in_flight)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if (sink_gaps) begin
				res_ch.ready <= ($urandom_range(99) >= 20);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	function automatic logic [21:0] random_cwnd();
		return ($urandom_range(3) == 0) ? 22'($urandom_range(4194303)) : 22'($urandom_range(64));
	endfunction

	task automatic apb_write(input logic idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Valid stays high between back-to-back items; it is only lowered for a gap.
	task automatic send_event(input logic [2:0] func, input logic [31:0] acked,
		input logic [31:0] snd_next, input logic [31:0] deliv, input logic [31:0] marked,
		input logic [21:0] cwnd);
		while (source_gaps && $urandom_range(99) < 20) begin
			evt_ch.valid <= 1'b0;
			@(posedge clk);
		end
		evt_ch.valid <= 1'b1;
		evt_ch.func <= func;
		evt_ch.acked_seq <= acked;
		evt_ch.send_next_seq <= snd_next;
		evt_ch.delivered_count <= deliv;
		evt_ch.marked_count <= marked;
		evt_ch.cwnd <= cwnd;
		@(posedge clk);
		while (!evt_ch.ready) @(posedge clk);
	endtask

	task automatic drain_results();
		evt_ch.valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
	endtask

	task automatic start_flow();
		una = $urandom();
		nxt = una + $urandom_range(1, 5000);
		dlv = $urandom();
		mrk = $urandom();
		send_event(FUNC_INIT, una, nxt, dlv, mrk, random_cwnd());
	endtask

	task automatic random_event();
		int unsigned pick;
		int unsigned dk;
		int unsigned mk;
		pick = $urandom_range(99);
		if (pick < 60) begin
			dk = ($urandom_range(9) == 0) ? $urandom_range(5000) : $urandom_range(40);
			case ($urandom_range(3))
			0: mk = 0;
			1: mk = dk;
			default: mk = $urandom_range(dk);
			endcase
			una += $urandom_range(3000);
			nxt += $urandom_range(4000);
			// The send pointer never falls behind the acked pointer.
			if ((nxt - una) >= 32'h8000_0000)
				nxt = una + $urandom_range(2000);
			dlv += dk;
			mrk += mk;
			send_event(FUNC_ACK, una, nxt, dlv, mrk, random_cwnd());
		end else if (pick < 72) begin
			case ($urandom_range(2))
			0: send_event(FUNC_SSTHRESH, $urandom(), $urandom(), $urandom(), $urandom(),
				random_cwnd());
			1: send_event(FUNC_LOSS, $urandom(), $urandom(), $urandom(), $urandom(),
				random_cwnd());
			default: send_event(FUNC_UNDO, $urandom(), $urandom(), $urandom(), $urandom(),
				random_cwnd());
			endcase
		end else if (pick < 76) begin
			start_flow();
		end else if (pick < 90) begin
			send_event(3'($urandom_range(7)), $urandom(), $urandom(), $urandom(), $urandom(),
				22'($urandom()));
		end else begin
			// Broken flow: counters jump arbitrarily and marks may exceed deliveries.
			una = ($urandom_range(1) == 0) ? $urandom() : una + $urandom_range(100000);
			nxt = $urandom();
			dlv += $urandom();
			mrk += $urandom();
			send_event(FUNC_ACK, una, nxt, dlv, mrk, random_cwnd());
		end
	endtask

	initial begin : stimulus
		logic [3:0]  g;
		logic [10:0] a;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		evt_ch.valid = 1'b0;
		evt_ch.func = FUNC_ACK;
		evt_ch.acked_seq = '0;
		evt_ch.send_next_seq = '0;
		evt_ch.delivered_count = '0;
		evt_ch.marked_count = '0;
		evt_ch.cwnd = '0;
		source_gaps = 1'b1;
		sink_gaps = 1'b1;
		hold_request = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items with the reset configuration.
		send_event(FUNC_ACK, 32'd0, 32'd100, 32'd0, 32'd0, 22'd0);
		send_event(FUNC_ACK, 32'd99, 32'd200, 32'd5, 32'd5, 22'd0);
		send_event(FUNC_INIT, 32'd0, 32'd1000, 32'd100, 32'd50, 22'd7);
		// No deliveries in the window: the divisor is forced to one and alpha saturates.
		send_event(FUNC_ACK, 32'd1000, 32'd5000, 32'd100, 32'd60, 22'd0);
		// Marked delta of all ones loses its top bits in the scaling.
		send_event(FUNC_ACK, 32'd5000, 32'hFFFF_FF00, 32'd99, 32'd59, 22'h3FFFFF);
		// Acked sequence wrapped past the window end.
		send_event(FUNC_ACK, 32'h0000_0010, 32'h0000_0020, 32'd1099, 32'd309, 22'd0);
		send_event(FUNC_ACK, 32'h8000_0020, 32'h0000_0030, 32'd2000, 32'd400, 22'd0);
		send_event(FUNC_ACK, 32'h8000_001F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			22'd0);
		send_event(FUNC_SSTHRESH, '0, '0, '0, '0, 22'h3FFFFF);
		send_event(FUNC_SSTHRESH, '0, '0, '0, '0, 22'd0);
		send_event(FUNC_SSTHRESH, '0, '0, '0, '0, 22'd1);
		send_event(FUNC_SSTHRESH, '0, '0, '0, '0, 22'd3);
		send_event(FUNC_LOSS, '0, '0, '0, '0, 22'd0);
		send_event(FUNC_LOSS, '0, '0, '0, '0, 22'h3FFFFF);
		send_event(FUNC_LOSS, '0, '0, '0, '0, 22'd5);
		send_event(FUNC_UNDO, '0, '0, '0, '0, 22'd1);
		send_event(FUNC_UNDO, '0, '0, '0, '0, 22'h3FFFFF);
		send_event(3'd5, $urandom(), $urandom(), $urandom(), $urandom(), 22'd9);
		send_event(3'd6, $urandom(), $urandom(), $urandom(), $urandom(), 22'd9);
		send_event(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			22'h3FFFFF);

		for (int phase = 0; phase < 8; phase++) begin
			g = (phase == RANDOM_PHASE) ? 4'($urandom_range(15)) : GAIN_PLAN[phase];
			a = (phase == RANDOM_PHASE) ? 11'($urandom_range(2047)) : INIT_PLAN[phase];
			drain_results();
			apb_write(REG_GAIN_SHIFT, {28'd0, g});
			apb_write(REG_INITIAL_ALPHA, {21'd0, a});
			source_gaps = (phase != STEADY_PHASE);
			sink_gaps = (phase != STEADY_PHASE);
			if (phase == HOLD_PHASE)
				hold_request = 1'b1;
			start_flow();
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				random_event();
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && in_flight == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[files.f]
hw/rtl/ecnmf_pkg.sv
hw/rtl/ecnmf_if.sv
hw/rtl/ecnmf_ctrl.sv
hw/rtl/ecnmf_dp.sv
hw/rtl/ecn_mark_fraction_estimator.sv
verif/ecnmf_alpha_checker.sv
verif/tb_ecn_mark_fraction_estimator.sv
